>>> rtl/spm_pkg.sv
// Shared types and constants of the surround panning mixer.
`timescale 1ns / 1ps
package spm_pkg;

  localparam int SmpW     = 16;  // Q1.15 source sample
  localparam int MonoW    = 17;  // mono in Q.16, no loss
  localparam int VolW     = 16;  // Q4.12 volume
  localparam int PanW     = 17;  // Q2.15 pan
  localparam int GainW    = 16;  // Q.15 gain, 0..32768
  localparam int WgtW     = 21;  // weighted sample, Q.15
  localparam int AccW     = 32;  // channel, mono and filter sums
  localparam int OutW     = 19;  // Q4.15 output
  localparam int CoefW    = 15;  // Q0.15 filter alpha
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  localparam logic [GainW-1:0] Unity = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LFE_COEF = 1'b0,
    CFG_CLAMP_EN = 1'b1
  } cfg_idx_e;

  // One classified beat as it sits in the queue.
  typedef struct packed {
    logic signed [MonoW-1:0] mono;
    logic [VolW-1:0]         volume;
    logic [GainW-1:0]        gain_l;
    logic [GainW-1:0]        gain_r;
    logic [GainW-1:0]        gain_c;
    logic [GainW-1:0]        gain_ls;
    logic [GainW-1:0]        gain_rs;
    logic                    sample_valid;
    logic                    end_of_frame;
    logic                    restart_filter;
  } spm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spm_q_stat_t;

  typedef struct packed {
    logic emit;   // output register loaded this cycle
    logic busy;   // back end holds an item
  } spm_bk_stat_t;

endpackage

>>> rtl/spm_if.sv
// Input and output stream interfaces of the surround panning mixer.
`timescale 1ns / 1ps
interface spm_in_if import spm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] sample_left;
  logic signed [SmpW-1:0] sample_right;
  logic                   stereo;
  logic [VolW-1:0]        volume;
  logic signed [PanW-1:0] pan;
  logic                   sample_valid;
  logic                   end_of_frame;
  logic                   restart_filter;

  modport source (
    output valid, sample_left, sample_right, stereo, volume, pan,
           sample_valid, end_of_frame, restart_filter,
    input  ready
  );
  modport sink (
    input  valid, sample_left, sample_right, stereo, volume, pan,
           sample_valid, end_of_frame, restart_filter,
    output ready
  );
endinterface

interface spm_out_if import spm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] left;
  logic signed [OutW-1:0] right;
  logic signed [OutW-1:0] center;
  logic signed [OutW-1:0] lfe;
  logic signed [OutW-1:0] surround_left;
  logic signed [OutW-1:0] surround_right;

  modport source (
    output valid, left, right, center, lfe, surround_left, surround_right,
    input  ready
  );
  modport sink (
    input  valid, left, right, center, lfe, surround_left, surround_right,
    output ready
  );
endinterface

>>> rtl/spm_front.sv
// Front end: takes input beats, forms mono and the pan gains, pushes to the queue.
`timescale 1ns / 1ps
module spm_front import spm_pkg::*; (
  spm_in_if.sink     smp_i,
  input  logic       q_full_i,
  output logic       push_o,
  output spm_item_t  item_o
);

  logic signed [PanW-1:0] pan_c;
  logic signed [PanW-1:0] pan_neg;
  logic [GainW-1:0]       mag;

  assign smp_i.ready = !q_full_i;
  assign push_o      = smp_i.valid && !q_full_i;

  always_comb begin
    // clamp pan to -1.0..+1.0
    if (smp_i.pan < -PanW'(32768)) begin
      pan_c = -PanW'(32768);
    end else if (smp_i.pan > PanW'(32768)) begin
      pan_c = PanW'(32768);
    end else begin
      pan_c = smp_i.pan;
    end
    pan_neg = -pan_c;
    mag     = pan_c[PanW-1] ? pan_neg[GainW-1:0] : pan_c[GainW-1:0];

    item_o.mono = smp_i.stereo
        ? (MonoW'(smp_i.sample_left) + MonoW'(smp_i.sample_right))
        : {smp_i.sample_left, 1'b0};
    item_o.volume         = smp_i.volume;
    item_o.sample_valid   = smp_i.sample_valid;
    item_o.end_of_frame   = smp_i.end_of_frame;
    item_o.restart_filter = smp_i.restart_filter;

    item_o.gain_l  = '0;
    item_o.gain_r  = '0;
    item_o.gain_ls = '0;
    item_o.gain_rs = '0;
    item_o.gain_c  = Unity - mag;
    if (pan_c[PanW-1]) begin
      item_o.gain_l  = Unity;
      item_o.gain_ls = mag;
    end else if (pan_c != '0) begin
      item_o.gain_r  = Unity;
      item_o.gain_rs = mag;
    end
  end

endmodule

>>> rtl/spm_queue.sv
// Short FIFO of classified beats between front and back end.
`timescale 1ns / 1ps
module spm_queue import spm_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  spm_item_t    item_i,
  input  logic         pop_i,
  output spm_item_t    item_o,
  output spm_q_stat_t  stat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  spm_item_t       slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign item_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= nxt(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= nxt(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/spm_back.sv
// Back end: weighting, five channel accumulators, LFE filter and output register.
`timescale 1ns / 1ps
module spm_back import spm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  spm_item_t         item_i,
  output logic              pop_o,
  input  logic [CoefW-1:0]  alpha_i,
  input  logic              clamp_i,
  spm_out_if.source         mix_o,
  output spm_bk_stat_t      stat_o
);

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_DIFF, S_FILT} state_e;

  state_e                 state_q;
  spm_item_t              cur_q;
  logic signed [WgtW-1:0] w_q;
  logic signed [AccW-1:0] sum_q [5];   // L, R, C, Ls, Rs
  logic signed [AccW-1:0] mono_q;
  logic signed [AccW-1:0] mem_q;
  logic signed [AccW:0]   diff_q;

  logic                        load;
  logic                        out_free;
  logic signed [MonoW+VolW:0]  wprod;
  logic signed [WgtW-1:0]      w_d;
  logic [4:0][GainW-1:0]       gain;
  logic signed [WgtW+GainW:0]  gprod [5];
  logic signed [AccW-1:0]      sum_d [5];
  logic signed [AccW-1:0]      mono_d;
  logic signed [AccW:0]        diff_d;
  logic signed [AccW+CoefW+1:0] lprod;
  logic signed [AccW-1:0]      mem_d;

  function automatic logic signed [AccW-1:0] sat(input logic signed [AccW+2:0] v);
    if (v > (AccW+3)'(32'sh7fff_ffff)) begin
      return {1'b0, {(AccW-1){1'b1}}};
    end else if (v < -(AccW+3)'(33'sh0_8000_0000)) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end
    return v[AccW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] emit(input logic signed [AccW-1:0] v,
                                                 input logic clamp);
    logic signed [AccW-1:0] r;
    r = v;
    if (r > 32'sd262143) begin
      r = 32'sd262143;
    end else if (r < -32'sd262144) begin
      r = -32'sd262144;
    end
    if (clamp) begin
      if (r > 32'sd32768) begin
        r = 32'sd32768;
      end else if (r < -32'sd32768) begin
        r = -32'sd32768;
      end
    end
    return r[OutW-1:0];
  endfunction

  assign out_free = !mix_o.valid || mix_o.ready;
  assign load     = q_valid_i &&
                    ((state_q == S_IDLE) || ((state_q == S_ACC) && !cur_q.end_of_frame));
  assign pop_o    = load;

  assign stat_o.emit = (state_q == S_FILT) && out_free;
  assign stat_o.busy = (state_q != S_IDLE);

  always_comb begin
    // w = rnd(mono * volume / 2^13)
    wprod = $signed(item_i.mono) * $signed({1'b0, item_i.volume});
    wprod = wprod + (MonoW+VolW+1)'(4096);
    w_d   = wprod[WgtW+12:13];

    gain = {cur_q.gain_rs, cur_q.gain_ls, cur_q.gain_c, cur_q.gain_r, cur_q.gain_l};
    for (int i = 0; i < 5; i++) begin
      gprod[i] = w_q * $signed({1'b0, gain[i]});
      gprod[i] = gprod[i] + (WgtW+GainW+1)'(16384);
      sum_d[i] = sat((AccW+3)'(sum_q[i]) + (AccW+3)'($signed(gprod[i][WgtW+GainW:15])));
    end
    mono_d = sat((AccW+3)'(mono_q) + (AccW+3)'(w_q));

    diff_d = (AccW+1)'(mono_q) - (AccW+1)'(mem_q);
    lprod  = diff_q * $signed({1'b0, alpha_i});
    lprod  = lprod + (AccW+CoefW+2)'(16384);
    mem_d  = sat((AccW+3)'(mem_q) + (AccW+3)'($signed(lprod[AccW+CoefW+1:15])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      cur_q                <= '0;
      w_q                  <= '0;
      mono_q               <= '0;
      mem_q                <= '0;
      diff_q               <= '0;
      for (int i = 0; i < 5; i++) begin
        sum_q[i] <= '0;
      end
      mix_o.valid          <= 1'b0;
      mix_o.left           <= '0;
      mix_o.right          <= '0;
      mix_o.center         <= '0;
      mix_o.lfe            <= '0;
      mix_o.surround_left  <= '0;
      mix_o.surround_right <= '0;
    end else begin
      if (mix_o.ready && !((state_q == S_FILT) && out_free)) begin
        mix_o.valid <= 1'b0;
      end
      if (load) begin
        cur_q <= item_i;
        w_q   <= w_d;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (cur_q.restart_filter) begin
            mem_q <= '0;
          end
          if (cur_q.sample_valid) begin
            for (int i = 0; i < 5; i++) begin
              sum_q[i] <= sum_d[i];
            end
            mono_q <= mono_d;
          end
          if (cur_q.end_of_frame) begin
            state_q <= S_DIFF;
          end else if (!load) begin
            state_q <= S_IDLE;
          end
        end
        S_DIFF: begin
          diff_q  <= diff_d;
          state_q <= S_FILT;
        end
        S_FILT: begin
          if (out_free) begin
            mem_q                <= mem_d;
            mix_o.valid          <= 1'b1;
            mix_o.left           <= emit(sum_q[0], clamp_i);
            mix_o.right          <= emit(sum_q[1], clamp_i);
            mix_o.center         <= emit(sum_q[2], clamp_i);
            mix_o.lfe            <= emit(mem_d, clamp_i);
            mix_o.surround_left  <= emit(sum_q[3], clamp_i);
            mix_o.surround_right <= emit(sum_q[4], clamp_i);
            for (int i = 0; i < 5; i++) begin
              sum_q[i] <= '0;
            end
            mono_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/surround_pan_mixer_with_lfe.sv
// Top level of the 5.1 surround panning mixer with LFE low-pass.
`timescale 1ns / 1ps
// Usage
//   smp_i : input beats, one source contribution each (sample pair, stereo
//           flag, Q4.12 volume, Q2.15 pan) plus frame flags. A beat with
//           sample_valid low adds nothing; end_of_frame closes the frame.
//   mix_o : one beat per frame with L, R, C, LFE, Ls, Rs in Q4.15.
//   cfg_* : write port; index 0 is the LFE alpha (Q0.15), index 1 the
//           output clamp enable. Write only while the mixer is idle.
// Throughput: one beat per cycle while a frame builds up; a frame-closing
//   beat holds the back end in accumulate, filter difference, filter update
//   (waits while mix_o is full), then idle, in which the next beat is loaded.
// A frame-closing beat into an empty queue is loaded by the back end, then
//   passes accumulate, filter difference and filter update before mix_o.
// Reset: sums, LFE memory, queue and output valid clear; alpha returns to
//   507 (about 120 Hz at 48 kHz) and the clamp is enabled.
// Stall: a finished frame waits in the output register; the back end holds
//   the next frame-closing beat in its filter step, the queue fills, then
//   smp_i drops ready.
module surround_pan_mixer_with_lfe import spm_pkg::*; #(
  parameter int FifoDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  spm_in_if.sink              smp_i,
  spm_out_if.source           mix_o
);

  logic [CoefW-1:0] lfe_coef_q;
  logic             clamp_en_q;

  logic          q_push;
  logic          q_pop;
  spm_item_t     q_in_item;
  spm_item_t     q_out_item;
  spm_q_stat_t   q_stat;
  spm_bk_stat_t  bk_stat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfe_coef_q <= CoefW'(507);
      clamp_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LFE_COEF: lfe_coef_q <= cfg_data_i[CoefW-1:0];
        CFG_CLAMP_EN: clamp_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front: mono fold, pan clamp, gain split
  spm_front u_front (
    .smp_i    (smp_i),
    .q_full_i (q_stat.full),
    .push_o   (q_push),
    .item_o   (q_in_item)
  );

  spm_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in_item),
    .pop_i  (q_pop),
    .item_o (q_out_item),
    .stat_o (q_stat)
  );

  // back: weighting, accumulation, LFE filter, output register
  spm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (!q_stat.empty),
    .item_i    (q_out_item),
    .pop_o     (q_pop),
    .alpha_i   (lfe_coef_q),
    .clamp_i   (clamp_en_q),
    .mix_o     (mix_o),
    .stat_o    (bk_stat)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_out_from_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mix_o.valid) |-> $past(bk_stat.emit))
    else $error("output beat without a filter step");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.emit |=> !bk_stat.busy)
    else $error("back end not idle after emitting a frame");

endmodule
